FILE: design/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache with prefetch.
// ----------------------------------------------------------------------------
package salc_pkg;
    localparam int MAX_SETS  = 512;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 48;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MAX_IB    = $clog2(MAX_SETS + 1) - 1;

    localparam logic [1:0] CFG_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_INDEX    = 2'd1;
    localparam logic [1:0] CFG_WAYS     = 2'd2;
    localparam logic [1:0] CFG_PREFETCH = 2'd3;

    typedef struct packed {
        logic load;
        logic use_next;
        logic read_set;
        logic write_set;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic busy;
    } t_status;
endpackage

FILE: design/set_assoc_lru_cache_with_prefetch_unit.sv
// Sequence: demand lookup and update, on a miss with prefetch enabled a
// prefetch lookup and fill, then the result register; a waiting result holds
// the next request. A new request is taken only in idle; the one-port set store
// is read and then, but for a prefetch hit, written back per set lookup.
// Reset: synchronous; registers take their defaults, and input is held off while
// a clearing pass over all 512 sets marks each line invalid, rank equal to its way.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_with_prefetch_unit
// Top level: configuration registers, sequencer and set datapath.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_with_prefetch_unit
    import salc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // hit, memory_reads[1:0], memory_write, prefetch_filled
);
    logic [3:0] r_offset_bits, r_index_bits, r_ways;
    logic       r_prefetch;
    t_cmd       cmd;
    t_status    status;
    logic [4:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd4;
            r_index_bits  <= 4'd0;
            r_ways        <= 4'd1;
            r_prefetch    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET:   r_offset_bits <= i_cfg_data;
                CFG_INDEX:    r_index_bits  <= i_cfg_data;
                CFG_WAYS:     r_ways        <= i_cfg_data;
                CFG_PREFETCH: r_prefetch    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    salc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_mode(s_axis_tuser), .i_prefetch(r_prefetch),
        .i_status(status), .o_cmd(cmd),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_result(result)
    );

    salc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_addr(s_axis_tdata),
        .i_offset_bits(r_offset_bits), .i_index_bits(r_index_bits),
        .i_ways(r_ways), .o_status(status)
    );

    assign m_axis_tdata = {3'b000, result};
endmodule

FILE: design/salc_datapath.sv
// ----------------------------------------------------------------------------
// salc_datapath
// Address split, set storage, tag compare, victim choice and LRU update.
// ----------------------------------------------------------------------------
module salc_datapath
    import salc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [3:0]           i_offset_bits,
    input  logic [3:0]           i_index_bits,
    input  logic [3:0]           i_ways,
    output t_status              o_status
);
    localparam int SW = MAX_WAYS * (ADDR_BITS + 1 + RANK_W);

    logic [SW-1:0]        r_mem [MAX_SETS];
    logic                 r_clearing;
    logic [SET_W-1:0]     r_clr_set;
    logic [SW-1:0]        r_rd;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;

    logic [3:0]           ib;
    logic [WCNT_W-1:0]    nw;
    logic [ADDR_BITS-1:0] cur;
    logic [ADDR_BITS-1:0] msk;
    logic [SET_W-1:0]     set_c;
    logic [ADDR_BITS-1:0] tag_c;
    logic [ADDR_BITS-1:0] tg   [MAX_WAYS];
    logic                 vl   [MAX_WAYS];
    logic [RANK_W-1:0]    rk   [MAX_WAYS];
    logic [SW-1:0]        n_wr;
    logic [SW-1:0]        clr_wd;
    logic                 hit;
    logic [WAY_W:0]       hw;
    logic [WAY_W:0]       inv_w;
    logic [WAY_W:0]       vic;
    logic [WAY_W:0]       sel;

    always_comb begin
        ib = (i_index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : i_index_bits;
        if (i_ways == 4'd0) nw = WCNT_W'(1);
        else if (i_ways > 4'(MAX_WAYS)) nw = WCNT_W'(MAX_WAYS);
        else nw = WCNT_W'(i_ways);
        cur = i_cmd.use_next ? (r_addr + (ADDR_BITS'(1) << i_offset_bits)) : i_addr;
        msk = (ADDR_BITS'(1) << ib) - ADDR_BITS'(1);
        set_c = SET_W'((cur >> i_offset_bits) & msk);
        tag_c = (cur >> i_offset_bits) >> ib;
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            clr_wd[w*(ADDR_BITS+1+RANK_W) +: ADDR_BITS] = '0;
            clr_wd[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS] = 1'b0;
            clr_wd[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS + 1 +: RANK_W] = RANK_W'(w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_set  <= '0;
        end else if (r_clearing) begin
            r_clr_set <= r_clr_set + 1'b1;
            if (r_clr_set == SET_W'(MAX_SETS - 1)) r_clearing <= 1'b0;
        end
        if (i_cmd.load) r_addr <= i_addr;
        if (i_cmd.read_set) begin
            r_set <= set_c;
            r_tag <= tag_c;
            r_rd  <= r_mem[set_c];
        end
        if (r_clearing) r_mem[r_clr_set] <= clr_wd;
        else if (i_cmd.write_set) r_mem[r_set] <= n_wr;
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tg[w] = r_rd[w*(ADDR_BITS+1+RANK_W) +: ADDR_BITS];
            vl[w] = r_rd[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS];
            rk[w] = r_rd[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS + 1 +: RANK_W];
        end
        hit = 1'b0;
        hw = '0;
        inv_w = '1;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (WCNT_W'(w) < nw) begin
                if (vl[w] && tg[w] == r_tag) begin
                    hit = 1'b1;
                    hw = (WAY_W+1)'(w);
                end
                if (!vl[w]) inv_w = (WAY_W+1)'(w);
            end
        end
        vic = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (WCNT_W'(w) < nw && rk[w] > rk[vic[WAY_W-1:0]]) vic = (WAY_W+1)'(w);
        end
        if (!inv_w[WAY_W]) vic = inv_w;
        sel = hit ? hw : vic;
        for (int w = 0; w < MAX_WAYS; w++) begin
            n_wr[w*(ADDR_BITS+1+RANK_W) +: ADDR_BITS] = tg[w];
            n_wr[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS] = vl[w];
            n_wr[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS + 1 +: RANK_W] = rk[w];
            if (WCNT_W'(w) < nw) begin
                if ((WAY_W+1)'(w) == sel) begin
                    n_wr[w*(ADDR_BITS+1+RANK_W) +: ADDR_BITS] = r_tag;
                    n_wr[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS] = 1'b1;
                    n_wr[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS + 1 +: RANK_W] = '0;
                end else if (rk[w] < rk[sel[WAY_W-1:0]] &&
                             rk[w] < RANK_W'(MAX_WAYS - 1)) begin
                    n_wr[w*(ADDR_BITS+1+RANK_W) + ADDR_BITS + 1 +: RANK_W] = rk[w] + 1'b1;
                end
            end
        end
        o_status.hit  = hit;
        o_status.busy = r_clearing;
    end
endmodule

FILE: design/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Access sequencer: demand lookup and update, optional prefetch pass, result.
// ----------------------------------------------------------------------------
module salc_ctrl
    import salc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_mode,
    input  logic    i_prefetch,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic [4:0] o_result
);
    typedef enum logic [2:0] {S_IDLE, S_DEMAND, S_PF_READ, S_PF, S_OUT} t_state;

    t_state     r_state, n_state;
    logic       r_mode, r_hit, r_pf;
    logic [1:0] r_reads;
    logic       r_out_valid;
    logic [4:0] r_result;
    logic       take;

    assign take = i_in_valid && !i_status.busy;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = take;
                o_cmd.read_set = take;
                if (take) n_state = S_DEMAND;
            end
            S_DEMAND: begin
                o_cmd.write_set = 1'b1;
                if (!i_status.hit && i_prefetch) n_state = S_PF_READ;
                else n_state = S_OUT;
            end
            S_PF_READ: begin
                o_cmd.use_next = 1'b1;
                o_cmd.read_set = 1'b1;
                n_state = S_PF;
            end
            S_PF: begin
                o_cmd.write_set = !i_status.hit;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !i_status.busy;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && take) r_mode <= i_mode;
            if (r_state == S_DEMAND) begin
                r_hit <= i_status.hit;
                r_reads <= i_status.hit ? 2'd0 : 2'd1;
                r_pf <= 1'b0;
            end
            if (r_state == S_PF && !i_status.hit) begin
                r_reads <= 2'd2;
                r_pf <= 1'b1;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_result <= {r_pf, r_mode, r_reads, r_hit};
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready outside idle");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.busy |-> !o_in_ready) else $error("ready while clearing");
    a_pf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_result[4] || o_result[2:1] == 2'd2)) else $error("pf reads");
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_result[0] || o_result[2:1] == 2'd0)) else $error("hit reads");
`endif
endmodule

FILE: verif/set_assoc_lru_cache_with_prefetch_unit_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_with_prefetch_unit_tb
// Drives cache accesses through the request stream, predicts hit, memory
// reads, write-through and prefetch fill per access with a local cache model,
// and compares every response in order. Geometry and prefetch are changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_with_prefetch_unit_tb;
    import salc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       hit;
        logic [1:0] reads;
        logic       wr;
        logic       pf;
    } t_resp;

    typedef struct packed {
        logic        mode;
        logic [47:0] addr;
    } t_acc;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    set_assoc_lru_cache_with_prefetch_unit u_dut (.*);

    logic [3:0]  cfg_ob, cfg_ib, cfg_ways;
    logic        cfg_pf;
    logic [47:0] tag_mem [MAX_SETS*MAX_WAYS];
    logic        vld_mem [MAX_SETS*MAX_WAYS];
    logic [2:0]  rank_mem [MAX_SETS*MAX_WAYS];

    t_resp resp_q[$];
    t_acc  acc_q[$];
    int    errors = 0;
    int    cycles = 0;
    bit    hold_rx = 0;
    bit    rx_pat = 0;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic int n_ways();
        if (cfg_ways == 0) return 1;
        if (cfg_ways > MAX_WAYS) return MAX_WAYS;
        return cfg_ways;
    endfunction

    function automatic int n_ib();
        int k;
        k = cfg_ib;
        while (k > 0 && (1 << k) > MAX_SETS) k--;
        return k;
    endfunction

    function automatic void split(input logic [47:0] a, output int base,
                                  output logic [47:0] tg);
        logic [63:0] s;
        int ob, ib;
        ob = cfg_ob;
        ib = n_ib();
        s = ({16'd0, a} >> ob) & ((64'd1 << ib) - 64'd1);
        base = int'(s) * MAX_WAYS;
        tg = 48'({16'd0, a} >> (ob + ib));
    endfunction

    function automatic void make_recent(int base, int w, int nw);
        logic [2:0] r;
        r = rank_mem[base+w];
        for (int i = 0; i < nw; i++)
            if (i != w && rank_mem[base+i] < r && rank_mem[base+i] < MAX_WAYS-1)
                rank_mem[base+i]++;
        rank_mem[base+w] = '0;
    endfunction

    function automatic bit find_line(int base, logic [47:0] tg, int nw, output int w);
        w = 0;
        for (int i = 0; i < nw; i++)
            if (vld_mem[base+i] && tag_mem[base+i] == tg) begin
                w = i;
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic void fill_line(int base, logic [47:0] tg, int nw);
        int v;
        bit got;
        v = 0;
        got = 0;
        for (int i = 0; i < nw; i++)
            if (!got && !vld_mem[base+i]) begin
                v = i;
                got = 1;
            end
        if (!got)
            for (int i = 1; i < nw; i++)
                if (rank_mem[base+i] > rank_mem[base+v]) v = i;
        tag_mem[base+v] = tg;
        vld_mem[base+v] = 1'b1;
        make_recent(base, v, nw);
    endfunction

    function automatic t_resp cache_access(t_acc a);
        t_resp r;
        int base, nbase, w, nw;
        logic [47:0] tg, ntg, nxt;
        r = '0;
        r.wr = a.mode;
        nw = n_ways();
        split(a.addr, base, tg);
        if (find_line(base, tg, nw, w)) begin
            r.hit = 1'b1;
            make_recent(base, w, nw);
        end else begin
            fill_line(base, tg, nw);
            r.reads = 2'd1;
            if (cfg_pf) begin
                nxt = 48'({16'd0, a.addr} + (64'd1 << cfg_ob));
                split(nxt, nbase, ntg);
                if (!find_line(nbase, ntg, nw, w)) begin
                    fill_line(nbase, ntg, nw);
                    r.reads = 2'd2;
                    r.pf = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [3:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OFFSET:   cfg_ob = val;
            CFG_INDEX:    cfg_ib = val;
            CFG_WAYS:     cfg_ways = val;
            CFG_PREFETCH: cfg_pf = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw, logic pf);
        wait_idle();
        cfg_write(CFG_OFFSET, ob);
        cfg_write(CFG_INDEX, ib);
        cfg_write(CFG_WAYS, nw);
        cfg_write(CFG_PREFETCH, {3'd0, pf});
    endtask

    task automatic send_access(t_acc a);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= a.addr;
        s_axis_tuser <= a.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        resp_q.push_back(cache_access(a));
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [47:0] rand_addr(int span_bits);
        logic [47:0] a;
        a = 48'({$urandom(), $urandom()});
        if (span_bits < 48) a = a & ((48'd1 << span_bits) - 48'd1);
        return a;
    endfunction

    task automatic random_phase(int cnt, int span);
        t_acc a;
        for (int n = 0; n < cnt; n++) begin
            a.mode = 1'($urandom_range(0, 1));
            a.addr = rand_addr(span);
            if ($urandom_range(0, 9) == 0) a.addr = rand_addr(48);
            send_access(a);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // directed table: first rows have fixed expected results after reset
    t_acc  dir_acc [12];
    t_resp dir_exp [4];
    initial begin
        dir_acc[0] = '{1'b0, 48'h0};
        dir_acc[1] = '{1'b1, 48'h0};
        dir_acc[2] = '{1'b0, 48'hFFFF_FFFF_FFFF};
        dir_acc[3] = '{1'b1, 48'h0F};
        dir_acc[4] = '{1'b0, 48'h10};
        dir_acc[5] = '{1'b1, 48'h8000_0000_0000};
        dir_acc[6] = '{1'b0, 48'hFFFF_FFFF_FFF0};
        dir_acc[7] = '{1'b1, 48'h5555_5555_5555};
        dir_acc[8] = '{1'b0, 48'hAAAA_AAAA_AAAA};
        dir_acc[9] = '{1'b0, 48'h20};
        dir_acc[10] = '{1'b1, 48'h30};
        dir_acc[11] = '{1'b0, 48'h20};
        dir_exp[0] = '{1'b0, 2'd1, 1'b0, 1'b0};
        dir_exp[1] = '{1'b1, 2'd0, 1'b1, 1'b0};
        dir_exp[2] = '{1'b0, 2'd1, 1'b0, 1'b0};
        dir_exp[3] = '{1'b0, 2'd1, 1'b1, 1'b0};
    end

    initial begin
        t_resp p;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_OFFSET;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_ob = 4'd4; cfg_ib = 4'd0; cfg_ways = 4'd1; cfg_pf = 1'b0;
        for (int i = 0; i < MAX_SETS*MAX_WAYS; i++) begin
            tag_mem[i] = '0;
            vld_mem[i] = 1'b0;
            rank_mem[i] = 3'(i % MAX_WAYS);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 12; i++) begin
            if (i == 4) begin
                s_axis_tvalid <= 1'b0;
                set_geometry(4, 2, 2, 1);
            end
            if (i < 4) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= dir_acc[i].addr;
                s_axis_tuser <= dir_acc[i].mode;
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                p = cache_access(dir_acc[i]);
                if (p != dir_exp[i]) begin
                    $display("%0t predictor row %0d: expected %h actual %h",
                             $time, i, dir_exp[i], p);
                    errors++;
                end
                resp_q.push_back(dir_exp[i]);
            end else begin
                send_access(dir_acc[i]);
            end
        end
        s_axis_tvalid <= 1'b0;
        set_geometry(0, 0, 8, 1);
        random_phase(90, 8);
        set_geometry(12, 9, 8, 0);
        random_phase(90, 30);
        set_geometry(15, 15, 15, 1);
        random_phase(60, 24);
        set_geometry(2, 3, 4, 1);
        hold_rx = 1;
        fork
            random_phase(90, 9);
            begin
                repeat (200) @(posedge i_clk);
                hold_rx = 0;
            end
        join
        set_geometry(4, 2, 0, 0);
        random_phase(80, 10);
        set_geometry(3, 4, 3, 1);
        random_phase(100, 12);
        wait_idle();
        cfg_write(CFG_WAYS, 7);
        random_phase(80, 12);
        set_geometry(1, 1, 2, 1);
        random_phase(80, 5);
        set_geometry(5, 6, 8, 1);
        random_phase(80, 14);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && resp_q.size() == 0) begin
            $display("set_assoc_lru_cache_with_prefetch_unit_tb passed");
        end else begin
            $display("set_assoc_lru_cache_with_prefetch_unit_tb failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_rx) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 31) == 0) rx_pat = ~rx_pat;
            m_axis_tready <= rx_pat ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_resp e, g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            g = {m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[3], m_axis_tdata[4]};
            if (resp_q.size() == 0) begin
                $display("%0t unexpected response: expected none actual %h", $time, g);
                errors++;
            end else begin
                e = resp_q.pop_front();
                if (g.hit !== e.hit) begin
                    $display("%0t hit: expected %b actual %b", $time, e.hit, g.hit);
                    errors++;
                end
                if (g.reads !== e.reads) begin
                    $display("%0t reads: expected %0d actual %0d", $time, e.reads, g.reads);
                    errors++;
                end
                if (g.wr !== e.wr) begin
                    $display("%0t write: expected %b actual %b", $time, e.wr, g.wr);
                    errors++;
                end
                if (g.pf !== e.pf) begin
                    $display("%0t prefetch: expected %b actual %b", $time, e.pf, g.pf);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("set_assoc_lru_cache_with_prefetch_unit_tb failed");
            $finish;
        end
    end
endmodule
